// ===== rtl/handheld_console_memory_bus_macros.svh =====
// Assertion macros for the handheld console memory bus.
// Used by the top level; expects clk and arst_n in scope.
`ifndef HANDHELD_CONSOLE_MEMORY_BUS_MACROS_SVH
`define HANDHELD_CONSOLE_MEMORY_BUS_MACROS_SVH

// same-cycle implication
`define HCMB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcmb assertion failed");

// next-cycle implication
`define HCMB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcmb assertion failed");

`endif

// ===== rtl/hcmb_pkg.sv =====
// Package for the handheld console memory bus: address map constants, request bits,
// region and store codes, external target codes, state type. No dependencies.
`timescale 1ns / 1ps
package hcmb_pkg;

	localparam int BOOT_BYTES_DEF     = 256;
	localparam int CART_BYTES_DEF     = 32768;
	localparam int RAM_BYTES_DEF      = 8192;
	localparam int HIGH_RAM_BYTES_DEF = 128;

	localparam int WORD_BIT  = 0;
	localparam int WRITE_BIT = 1;

	localparam logic [15:0] ADDR_BOOT_EXIT = 16'h0100;
	localparam logic [15:0] ADDR_ROM_BANK1 = 16'h4000;
	localparam logic [15:0] ADDR_VRAM      = 16'h8000;
	localparam logic [15:0] ADDR_ERAM      = 16'hA000;
	localparam logic [15:0] ADDR_WRAM      = 16'hC000;
	localparam logic [15:0] ADDR_OAM       = 16'hFE00;
	localparam logic [15:0] ADDR_GAP       = 16'hFEA0;
	localparam logic [15:0] ADDR_IO        = 16'hFF00;
	localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
	localparam logic [15:0] ADDR_IE        = 16'hFFFF;

	localparam logic [15:0] IO_JOYP = 16'hFF00;
	localparam logic [15:0] IO_LCDC = 16'hFF40;
	localparam logic [15:0] IO_SCY  = 16'hFF42;
	localparam logic [15:0] IO_SCX  = 16'hFF43;
	localparam logic [15:0] IO_LY   = 16'hFF44;
	localparam logic [15:0] IO_BGP  = 16'hFF47;
	localparam logic [15:0] IO_OBP0 = 16'hFF48;
	localparam logic [15:0] IO_OBP1 = 16'hFF49;

	localparam logic [3:0] TGT_NONE = 4'd0;
	localparam logic [3:0] TGT_VRAM = 4'd1;
	localparam logic [3:0] TGT_OAM  = 4'd2;
	localparam logic [3:0] TGT_JOYP = 4'd3;
	localparam logic [3:0] TGT_LCDC = 4'd4;
	localparam logic [3:0] TGT_SCY  = 4'd5;
	localparam logic [3:0] TGT_SCX  = 4'd6;
	localparam logic [3:0] TGT_LY   = 4'd7;
	localparam logic [3:0] TGT_BGP  = 4'd8;
	localparam logic [3:0] TGT_OBP0 = 4'd9;
	localparam logic [3:0] TGT_OBP1 = 4'd10;

	typedef enum logic [3:0] {
		RG_BOOT, RG_ROM, RG_VRAM, RG_ERAM, RG_WRAM, RG_OAM, RG_NONE, RG_IO, RG_HRAM
	} region_t;

	typedef enum logic [2:0] {
		SS_BOOT, SS_CART, SS_ERAM, SS_WRAM, SS_HRAM
	} store_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_SECOND, ST_DONE
	} state_t;

endpackage

// ===== rtl/hcmb_store.sv =====
// Local byte stores of the memory bus: boot, cartridge, external, work and high RAM
// share one byte-wide memory, one access per cycle, registered read data. Depends on hcmb_pkg.
`timescale 1ns / 1ps
module hcmb_store #(
	parameter int BOOT_BYTES     = hcmb_pkg::BOOT_BYTES_DEF,
	parameter int CART_BYTES     = hcmb_pkg::CART_BYTES_DEF,
	parameter int RAM_BYTES      = hcmb_pkg::RAM_BYTES_DEF,
	parameter int HIGH_RAM_BYTES = hcmb_pkg::HIGH_RAM_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          we,
	input  hcmb_pkg::store_sel_t          sel,
	input  logic [$clog2(CART_BYTES)-1:0] idx,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    rdata
);
	import hcmb_pkg::*;

	localparam int BW = $clog2(BOOT_BYTES);
	localparam int CW = $clog2(CART_BYTES);
	localparam int RW = $clog2(RAM_BYTES);
	localparam int HW = $clog2(HIGH_RAM_BYTES);

	localparam int BOOT_BASE = 0;
	localparam int CART_BASE = BOOT_BASE + BOOT_BYTES;
	localparam int ERAM_BASE = CART_BASE + CART_BYTES;
	localparam int WRAM_BASE = ERAM_BASE + RAM_BYTES;
	localparam int HRAM_BASE = WRAM_BASE + RAM_BYTES;
	localparam int MEM_BYTES = HRAM_BASE + HIGH_RAM_BYTES;
	localparam int AW        = $clog2(MEM_BYTES);

	logic [7:0]    mem [MEM_BYTES];
	logic [7:0]    rdata_q;
	logic [AW-1:0] addr;

	always_comb begin
		unique case (sel)
			SS_BOOT: addr = AW'(BOOT_BASE) + AW'(idx[BW-1:0]);
			SS_CART: addr = AW'(CART_BASE) + AW'(idx[CW-1:0]);
			SS_ERAM: addr = AW'(ERAM_BASE) + AW'(idx[RW-1:0]);
			SS_WRAM: addr = AW'(WRAM_BASE) + AW'(idx[RW-1:0]);
			SS_HRAM: addr = AW'(HRAM_BASE) + AW'(idx[HW-1:0]);
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[addr] <= wdata;
			else    rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/handheld_console_memory_bus.sv =====
// Flow: a transfer is registered and a local access uses the store; a local word makes
// its second byte access in ST_SECOND, the stores having a single byte-wide port. ST_DONE
// loads the result register once the output does not stall; forwarded and unmapped
// accesses go straight to ST_DONE. One item at a time: in_stall holds until the result loads.
// Reset: boot overlay on, state idle, no result pending; stores not initialized.
`timescale 1ns / 1ps
`include "handheld_console_memory_bus_macros.svh"
module handheld_console_memory_bus #(
	parameter int BOOT_BYTES     = hcmb_pkg::BOOT_BYTES_DEF,
	parameter int CART_BYTES     = hcmb_pkg::CART_BYTES_DEF,
	parameter int RAM_BYTES      = hcmb_pkg::RAM_BYTES_DEF,
	parameter int HIGH_RAM_BYTES = hcmb_pkg::HIGH_RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_addr,
	input  logic [15:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data,
	output logic [3:0]  ext_target,
	output logic [12:0] ext_offset,
	output logic        ext_is_write,
	output logic        ext_is_word,
	output logic [15:0] ext_write_data
);
	import hcmb_pkg::*;

	localparam int BW    = $clog2(BOOT_BYTES);
	localparam int CW    = $clog2(CART_BYTES);
	localparam int RW    = $clog2(RAM_BYTES);
	localparam int HW    = $clog2(HIGH_RAM_BYTES);
	localparam int IDX_W = CW;

	state_t state_q, state_d;
	logic   boot_on_q;

	logic       acc, is_word, is_wr, is_local;
	region_t    region;
	store_sel_t sel;
	logic [IDX_W-1:0] idx0, idx1;
	logic [3:0]  tgt;
	logic [12:0] off;

	store_sel_t       sel_q;
	logic [IDX_W-1:0] idx1_q;
	logic [7:0]       wd_hi_q, lo_q;
	logic             rd_local_q, word_q, wr_q;
	logic [3:0]       tgt_q;
	logic [12:0]      off_q;
	logic             xwr_q, xword_q;
	logic [15:0]      xdata_q;

	logic             out_valid_q;
	logic [15:0]      read_data_q, xdata_out_q;
	logic [3:0]       tgt_out_q;
	logic [12:0]      off_out_q;
	logic             xwr_out_q, xword_out_q;

	logic             mem_en, mem_we;
	store_sel_t       mem_sel;
	logic [IDX_W-1:0] mem_idx;
	logic [7:0]       mem_wdata, mem_rdata;
	logic             out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign is_word  = req_type[WORD_BIT];
	assign is_wr    = req_type[WRITE_BIT];

	always_comb begin
		if (bus_addr < ADDR_ROM_BANK1)
			region = (bus_addr < ADDR_BOOT_EXIT && boot_on_q) ? RG_BOOT : RG_ROM;
		else if (bus_addr < ADDR_VRAM) region = RG_ROM;
		else if (bus_addr < ADDR_ERAM) region = RG_VRAM;
		else if (bus_addr < ADDR_WRAM) region = RG_ERAM;
		else if (bus_addr < ADDR_OAM)  region = RG_WRAM;
		else if (bus_addr < ADDR_GAP)  region = RG_OAM;
		else if (bus_addr < ADDR_IO)   region = RG_NONE;
		else if (bus_addr < ADDR_HRAM) region = RG_IO;
		else if (bus_addr < ADDR_IE)   region = RG_HRAM;
		else                           region = RG_NONE;
	end

	always_comb begin
		is_local = 1'b1;
		sel      = SS_CART;
		idx0     = IDX_W'(bus_addr[CW-1:0]);
		idx1     = IDX_W'({bus_addr[CW-1], (CW-1)'(bus_addr[CW-2:0] + 1'b1)});
		tgt      = TGT_NONE;
		off      = 13'd0;
		unique case (region)
			RG_BOOT: begin
				sel  = SS_BOOT;
				idx0 = IDX_W'(bus_addr[BW-1:0]);
				idx1 = IDX_W'(BW'(bus_addr[BW-1:0] + 1'b1));
			end
			RG_ROM: begin
				sel = SS_CART;
			end
			RG_ERAM, RG_WRAM: begin
				sel  = (region == RG_ERAM) ? SS_ERAM : SS_WRAM;
				idx0 = IDX_W'(bus_addr[RW-1:0]);
				idx1 = IDX_W'(RW'(bus_addr[RW-1:0] + 1'b1));
			end
			RG_HRAM: begin
				sel  = SS_HRAM;
				idx0 = IDX_W'(bus_addr[HW-1:0]);
				idx1 = IDX_W'(HW'(bus_addr[HW-1:0] + 1'b1));
			end
			RG_VRAM: begin
				is_local = 1'b0;
				tgt      = TGT_VRAM;
				off      = 13'(bus_addr - ADDR_VRAM);
			end
			RG_OAM: begin
				is_local = 1'b0;
				tgt      = TGT_OAM;
				off      = 13'(bus_addr - ADDR_OAM);
			end
			RG_IO: begin
				is_local = 1'b0;
				if (!is_word) begin
					unique case (bus_addr)
						IO_JOYP: tgt = TGT_JOYP;
						IO_LCDC: tgt = TGT_LCDC;
						IO_SCY:  tgt = TGT_SCY;
						IO_SCX:  tgt = TGT_SCX;
						IO_LY:   tgt = TGT_LY;
						IO_BGP:  tgt = TGT_BGP;
						IO_OBP0: tgt = TGT_OBP0;
						IO_OBP1: tgt = TGT_OBP1;
						default: tgt = TGT_NONE;
					endcase
				end
			end
			default: begin
				is_local = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_on_q <= 1'b1;
		end else if (acc && bus_addr == ADDR_BOOT_EXIT) begin
			boot_on_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sel_q      <= sel;
			idx1_q     <= idx1;
			wd_hi_q    <= write_data[15:8];
			rd_local_q <= is_local && !is_wr;
			word_q     <= is_word;
			wr_q       <= is_wr;
			tgt_q      <= tgt;
			off_q      <= off;
			xwr_q      <= (tgt != TGT_NONE) && is_wr;
			xword_q    <= (tgt != TGT_NONE) && is_word;
			if (tgt != TGT_NONE && is_wr)
				xdata_q <= is_word ? write_data : {8'h00, write_data[7:0]};
			else
				xdata_q <= 16'h0000;
		end
		if (state_q == ST_SECOND)
			lo_q <= mem_rdata;
	end

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = is_wr;
		mem_sel   = sel;
		mem_idx   = idx0;
		mem_wdata = write_data[7:0];
		if (state_q == ST_SECOND) begin
			mem_en    = 1'b1;
			mem_we    = wr_q;
			mem_sel   = sel_q;
			mem_idx   = idx1_q;
			mem_wdata = wd_hi_q;
		end else if (acc && is_local) begin
			mem_en = 1'b1;
		end
	end

	hcmb_store #(
		.BOOT_BYTES     (BOOT_BYTES),
		.CART_BYTES     (CART_BYTES),
		.RAM_BYTES      (RAM_BYTES),
		.HIGH_RAM_BYTES (HIGH_RAM_BYTES)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.sel   (mem_sel),
		.idx   (mem_idx),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_d = (is_local && is_word) ? ST_SECOND : ST_DONE;
			end
			ST_SECOND: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!rd_local_q)  read_data_q <= 16'h0000;
			else if (word_q)  read_data_q <= {mem_rdata, lo_q};
			else              read_data_q <= {8'h00, mem_rdata};
			tgt_out_q   <= tgt_q;
			off_out_q   <= off_q;
			xwr_out_q   <= xwr_q;
			xword_out_q <= xword_q;
			xdata_out_q <= xdata_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign ext_target     = tgt_out_q;
	assign ext_offset     = off_out_q;
	assign ext_is_write   = xwr_out_q;
	assign ext_is_word    = xword_out_q;
	assign ext_write_data = xdata_out_q;

	`HCMB_ASSERT_NEXT(a_busy_after_transfer, acc, in_stall)
	`HCMB_ASSERT_NEXT(a_word_two_accesses, acc && is_local && is_word, state_q == ST_SECOND)
	`HCMB_ASSERT_NEXT(a_overlay_stays_off, !boot_on_q, !boot_on_q)
	`HCMB_ASSERT_SAME(a_done_free_loads, state_q == ST_DONE && !out_valid_q, out_load)

endmodule
